FILE: rtl/core/gsp_pkg.sv
// Shared types, constants and field layouts for the generational slot pool.
// Used by every module of the block but gsp_ram; depends on nothing.
package gsp_pkg;

    localparam int MAX_SLOTS      = 1024;
    localparam int POOL_COUNT_DEF = 3;
    localparam int SLOT_W         = 10;
    localparam int GEN_W          = 8;
    localparam int OWNER_W        = 32;
    localparam int WORD_W         = 64;
    localparam int N_WORDS        = 5;
    localparam int CAP_W          = 11;
    localparam int CNT_W          = 10;
    localparam int SHAPE_W        = 3;
    localparam int KIND_W         = 2;
    localparam int META_W         = GEN_W + 1;
    localparam int DATA_W         = N_WORDS * WORD_W + OWNER_W;

    localparam int IN_DATA_W  = 376;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 384;
    localparam int OUT_USER_W = 1;

    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(1024);
    localparam logic [CAP_W-1:0] CAP_LIMIT   = CAP_W'(MAX_SLOTS);
    localparam logic [CAP_W-1:0] HW_RESET    = CAP_W'(1);

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_SPHERE  = 3'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_CAPSULE = 3'd2;

    localparam logic [GEN_W-1:0] GEN_MAX   = 8'hFF;
    localparam logic [GEN_W-1:0] GEN_FIRST = 8'd1;

    typedef logic [N_WORDS-1:0][WORD_W-1:0] t_payload;

    // Slave-side tdata, lowest field last.
    typedef struct packed {
        logic [5:0]         pad;
        logic [WORD_W-1:0]  payload_e;
        logic [WORD_W-1:0]  payload_d;
        logic [WORD_W-1:0]  payload_c;
        logic [WORD_W-1:0]  payload_b;
        logic [WORD_W-1:0]  payload_a;
        logic [OWNER_W-1:0] owner_id;
        logic [GEN_W-1:0]   generation;
        logic [SLOT_W-1:0]  slot;
    } t_in_data;

    typedef struct packed {
        logic [SHAPE_W-1:0] shape;
        logic [KIND_W-1:0]  kind;
    } t_in_user;

    // Master-side tdata, lowest field last.
    typedef struct packed {
        logic [3:0]         pad;
        logic [CNT_W-1:0]   pool_live_count;
        logic [WORD_W-1:0]  out_payload_e;
        logic [WORD_W-1:0]  out_payload_d;
        logic [WORD_W-1:0]  out_payload_c;
        logic [WORD_W-1:0]  out_payload_b;
        logic [WORD_W-1:0]  out_payload_a;
        logic [OWNER_W-1:0] out_owner;
        logic [GEN_W-1:0]   out_generation;
        logic [SLOT_W-1:0]  out_slot;
    } t_out_data;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SHAPE_W-1:0] shape;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   generation;
        logic [OWNER_W-1:0] owner_id;
        t_payload           payload;
    } t_item;

    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic             live;
    } t_meta;

    typedef struct packed {
        logic               success;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
        logic [OWNER_W-1:0] owner;
        t_payload           payload;
        logic [CNT_W-1:0]   count;
    } t_result;

    typedef struct packed {
        logic              en;
        logic              head_we;
        logic [SLOT_W-1:0] head_val;
        logic              hw_inc;
        logic              live_inc;
        logic              live_dec;
    } t_pool_upd;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic fire;
    } t_seq_ctrl;

endpackage

FILE: rtl/core/gsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; every slot store of the pool is one of these.
module gsp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/gsp_seq.sv
// Two-state sequencer: take one transfer, then execute it once the result
// register is free. Depends on gsp_pkg.
module gsp_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_free,
    output gsp_pkg::t_seq_ctrl o_ctrl
);

    import gsp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.accept   = i_in_valid;
            end
            S_EXEC: begin
                o_ctrl.fire = i_out_free;
            end
            default: o_ctrl = '0;
        endcase
    end

endmodule

FILE: rtl/core/gsp_pool.sv
// Per-pool bookkeeping registers: free-list head, high-water mark, live count.
// Depends on gsp_pkg; updated by the execute unit through t_pool_upd.
module gsp_pool #(
    parameter int POOL_COUNT = gsp_pkg::POOL_COUNT_DEF,
    parameter int PW         = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [PW-1:0]              i_pool,
    input  gsp_pkg::t_pool_upd         i_upd,
    output logic [gsp_pkg::SLOT_W-1:0] o_head,
    output logic [gsp_pkg::CAP_W-1:0]  o_hw,
    output logic [gsp_pkg::CNT_W-1:0]  o_live
);

    import gsp_pkg::*;

    logic [SLOT_W-1:0] r_head [POOL_COUNT];
    logic [CAP_W-1:0]  r_hw   [POOL_COUNT];
    logic [CNT_W-1:0]  r_live [POOL_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < POOL_COUNT; p++) begin
                r_head[p] <= '0;
                r_hw[p]   <= HW_RESET;
                r_live[p] <= '0;
            end
        end else if (i_upd.en) begin
            if (i_upd.head_we) begin
                r_head[i_pool] <= i_upd.head_val;
            end
            if (i_upd.hw_inc) begin
                r_hw[i_pool] <= r_hw[i_pool] + 1'b1;
            end
            if (i_upd.live_inc) begin
                r_live[i_pool] <= r_live[i_pool] + 1'b1;
            end else if (i_upd.live_dec) begin
                r_live[i_pool] <= r_live[i_pool] - 1'b1;
            end
        end
    end

    assign o_head = r_head[i_pool];
    assign o_hw   = r_hw[i_pool];
    assign o_live = r_live[i_pool];

endmodule

FILE: rtl/core/gsp_exec.sv
// Execute unit: handle check, generation bump and write-back decisions for
// one operation. Depends on gsp_pkg; purely combinational.
module gsp_exec (
    input  gsp_pkg::t_item              i_item,
    input  logic [gsp_pkg::SLOT_W-1:0]  i_acc_slot,
    input  logic                        i_sup,
    input  logic                        i_take_ok,
    input  logic                        i_from_list,
    input  gsp_pkg::t_meta              i_meta,
    input  logic [gsp_pkg::SLOT_W-1:0]  i_link,
    input  logic [gsp_pkg::OWNER_W-1:0] i_owner_rd,
    input  gsp_pkg::t_payload           i_payload_rd,
    input  logic [gsp_pkg::CAP_W-1:0]   i_hw,
    input  logic [gsp_pkg::CNT_W-1:0]   i_live,
    input  logic [gsp_pkg::CAP_W-1:0]   i_cap,
    output gsp_pkg::t_result            o_res,
    output logic                        o_meta_we,
    output gsp_pkg::t_meta              o_meta_wd,
    output logic                        o_link_we,
    output logic                        o_data_we,
    output gsp_pkg::t_pool_upd          o_upd
);

    import gsp_pkg::*;

    logic             known;
    logic [GEN_W-1:0] old_gen;
    logic             old_live;
    logic [GEN_W-1:0] new_gen;
    logic             handle_ok;
    logic             ins_ok;
    logic             rem_ok;
    logic             look_ok;
    logic [CNT_W-1:0] live_next;

    // Entries at or above the high-water mark were never allocated.
    assign known    = ({1'b0, i_acc_slot} < i_hw);
    assign old_gen  = known ? i_meta.gen : '0;
    assign old_live = known & i_meta.live;
    assign new_gen  = (old_gen == GEN_MAX) ? GEN_FIRST : old_gen + 1'b1;

    assign handle_ok = i_sup && (i_acc_slot != '0) && ({1'b0, i_acc_slot} <= i_cap)
                       && old_live && (old_gen == i_item.generation);

    assign ins_ok  = (i_item.kind == KIND_INSERT) && (i_item.owner_id != '0)
                     && i_sup && i_take_ok;
    assign rem_ok  = (i_item.kind == KIND_REMOVE) && handle_ok;
    assign look_ok = (i_item.kind == KIND_LOOKUP) && handle_ok;

    always_comb begin
        live_next = i_live;
        if (ins_ok) begin
            live_next = i_live + 1'b1;
        end else if (rem_ok) begin
            live_next = i_live - 1'b1;
        end
    end

    always_comb begin
        o_res       = '0;
        o_res.count = i_sup ? live_next : '0;
        if (ins_ok) begin
            o_res.success = 1'b1;
            o_res.slot    = i_acc_slot;
            o_res.gen     = new_gen;
        end else if (rem_ok || look_ok) begin
            o_res.success = 1'b1;
            o_res.slot    = i_acc_slot;
            o_res.gen     = i_item.generation;
        end
        if (look_ok) begin
            o_res.owner   = i_owner_rd;
            o_res.payload = i_payload_rd;
            // Sphere has no half extent word; capsule has no half z.
            if (i_item.shape == SHAPE_SPHERE) begin
                o_res.payload[N_WORDS-1] = '0;
            end else if (i_item.shape == SHAPE_CAPSULE) begin
                o_res.payload[N_WORDS-1][WORD_W-1:WORD_W/2] = '0;
            end
        end
    end

    assign o_meta_we = ins_ok | rem_ok;
    assign o_meta_wd = ins_ok ? t_meta'{gen: new_gen, live: 1'b1}
                              : t_meta'{gen: old_gen, live: 1'b0};
    assign o_link_we = rem_ok;
    assign o_data_we = ins_ok;

    always_comb begin
        o_upd          = '0;
        o_upd.en       = ins_ok | rem_ok;
        o_upd.head_we  = (ins_ok && i_from_list) || rem_ok;
        o_upd.head_val = rem_ok ? i_acc_slot : i_link;
        o_upd.hw_inc   = ins_ok && !i_from_list;
        o_upd.live_inc = ins_ok;
        o_upd.live_dec = rem_ok;
    end

endmodule

FILE: rtl/core/generational_slot_pool_unit.sv
// Top level of the generational slot pool: stream ports, configuration
// register, slot stores and result register. Depends on gsp_pkg, gsp_seq,
// gsp_pool, gsp_exec and gsp_ram.
//
// Hands out generational handles (slot index plus 8-bit generation) from one
// pool per supported shape (sphere, box, capsule). Each transfer on the slave
// side is an insert, remove or lookup and produces exactly one result transfer
// on the master side. In the cycle the transfer is taken the slot is chosen
// (free-list head, else high-water mark) and one read is issued to the
// generation, link and data stores; in the execute state that follows, the
// shared execute unit checks the handle, bumps the generation and writes back
// at most one entry per store. The block takes no new transfer until the held
// one has executed; a stalled master side holds the execute cycle. Stores are
// not swept after reset: entries at or above a pool's high-water mark read as
// never allocated, so the block is ready straight out of reset. The capacity
// register may be written only while no operation is in flight.
module generational_slot_pool_unit #(
    parameter int POOL_COUNT = gsp_pkg::POOL_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // slot, generation, owner_id, payload_a .. payload_e, zero pad
    input  logic [gsp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind, shape
    input  logic [gsp_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // out_slot, out_generation, out_owner, out_payload_a .. out_payload_e,
    // pool_live_count, zero pad
    output logic [gsp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // success
    output logic [gsp_pkg::OUT_USER_W-1:0] o_m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gsp_pkg::CAP_W-1:0]      i_cfg_data
);

    import gsp_pkg::*;

    localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int DEPTH = POOL_COUNT * MAX_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] mk_addr(input logic [PW-1:0] p,
                                              input logic [SLOT_W-1:0] s);
        return AW'({p, s});
    endfunction

    t_in_data  in_d;
    t_in_user  in_u;
    t_seq_ctrl ctrl;

    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] eff_cap;

    t_item             r_item;
    logic [SLOT_W-1:0] r_acc_slot;
    logic              r_take_ok;
    logic              r_from_list;

    logic               r_out_valid;
    t_out_data          r_out_data;
    logic               r_out_success;
    logic               out_free;

    logic [SHAPE_W-1:0] sel_shape;
    logic               sup;
    logic [PW-1:0]      pool_idx;
    logic [SLOT_W-1:0]  pool_head;
    logic [CAP_W-1:0]   pool_hw;
    logic [CNT_W-1:0]   pool_live;

    logic              from_list;
    logic              take_ok;
    logic [SLOT_W-1:0] pick_slot;
    logic [SLOT_W-1:0] acc_slot_in;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;

    t_meta             meta_rd;
    logic [META_W-1:0] meta_rd_raw;
    logic [SLOT_W-1:0] link_rd;
    logic [DATA_W-1:0] data_rd;

    t_result           res;
    logic              meta_we;
    t_meta             meta_wd;
    logic              link_we;
    logic              data_we;
    t_pool_upd         upd;
    t_pool_upd         upd_gated;

    assign in_d = t_in_data'(i_s_axis_tdata);
    assign in_u = t_in_user'(i_s_axis_tuser);

    // Capacity register; a value above the slot count acts as the slot count.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    assign eff_cap = (r_cap > CAP_LIMIT) ? CAP_LIMIT : r_cap;

    // Sequencer
    assign out_free = !r_out_valid || i_m_axis_tready;

    gsp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    assign o_s_axis_tready = ctrl.in_ready;

    // Address the incoming shape while idle, the held one while executing.
    assign sel_shape = ctrl.in_ready ? in_u.shape : r_item.shape;
    assign sup       = ({1'b0, sel_shape} < (SHAPE_W + 1)'(POOL_COUNT));
    assign pool_idx  = sup ? sel_shape[PW-1:0] : '0;

    gsp_pool #(
        .POOL_COUNT (POOL_COUNT),
        .PW         (PW)
    ) u_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pool  (pool_idx),
        .i_upd   (upd_gated),
        .o_head  (pool_head),
        .o_hw    (pool_hw),
        .o_live  (pool_live)
    );

    // Slot choice for an insert: free-list head first, then the high-water mark.
    assign from_list   = (pool_head != '0);
    assign take_ok     = from_list || (pool_hw < eff_cap);
    assign pick_slot   = from_list ? pool_head : pool_hw[SLOT_W-1:0];
    assign acc_slot_in = (in_u.kind == KIND_INSERT) ? pick_slot : in_d.slot;

    // Hold the operation for the execute cycle.
    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_item.kind       <= in_u.kind;
            r_item.shape      <= in_u.shape;
            r_item.slot       <= in_d.slot;
            r_item.generation <= in_d.generation;
            r_item.owner_id   <= in_d.owner_id;
            r_item.payload    <= {in_d.payload_e, in_d.payload_d, in_d.payload_c,
                                  in_d.payload_b, in_d.payload_a};
            r_acc_slot        <= acc_slot_in;
            r_take_ok         <= take_ok;
            r_from_list       <= from_list;
        end
    end

    assign raddr = mk_addr(pool_idx, acc_slot_in);
    assign waddr = mk_addr(pool_idx, r_acc_slot);

    // Slot stores: generation with live bit, free-list link, owner and payload.
    gsp_ram #(
        .WIDTH (META_W),
        .DEPTH (DEPTH)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.fire & meta_we),
        .i_waddr (waddr),
        .i_wdata (meta_wd),
        .i_re    (ctrl.accept),
        .i_raddr (raddr),
        .o_rdata (meta_rd_raw)
    );

    assign meta_rd = t_meta'(meta_rd_raw);

    // The free-list push writes the current head into the removed slot's link.
    gsp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.fire & link_we),
        .i_waddr (waddr),
        .i_wdata (pool_head),
        .i_re    (ctrl.accept),
        .i_raddr (raddr),
        .o_rdata (link_rd)
    );

    gsp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.fire & data_we),
        .i_waddr (waddr),
        .i_wdata ({r_item.payload, r_item.owner_id}),
        .i_re    (ctrl.accept),
        .i_raddr (raddr),
        .o_rdata (data_rd)
    );

    gsp_exec u_exec (
        .i_item       (r_item),
        .i_acc_slot   (r_acc_slot),
        .i_sup        (sup),
        .i_take_ok    (r_take_ok),
        .i_from_list  (r_from_list),
        .i_meta       (meta_rd),
        .i_link       (link_rd),
        .i_owner_rd   (data_rd[OWNER_W-1:0]),
        .i_payload_rd (t_payload'(data_rd[DATA_W-1:OWNER_W])),
        .i_hw         (pool_hw),
        .i_live       (pool_live),
        .i_cap        (eff_cap),
        .o_res        (res),
        .o_meta_we    (meta_we),
        .o_meta_wd    (meta_wd),
        .o_link_we    (link_we),
        .o_data_we    (data_we),
        .o_upd        (upd)
    );

    // Pool registers move only on the execute cycle that completes.
    always_comb begin
        upd_gated    = upd;
        upd_gated.en = upd.en & ctrl.fire;
    end

    // Result register: load on execute, drop once the master side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.fire) begin
            r_out_success              <= res.success;
            r_out_data.pad             <= '0;
            r_out_data.pool_live_count <= res.count;
            r_out_data.out_payload_e   <= res.payload[4];
            r_out_data.out_payload_d   <= res.payload[3];
            r_out_data.out_payload_c   <= res.payload[2];
            r_out_data.out_payload_b   <= res.payload[1];
            r_out_data.out_payload_a   <= res.payload[0];
            r_out_data.out_owner       <= res.owner;
            r_out_data.out_generation  <= res.gen;
            r_out_data.out_slot        <= res.slot;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_success;

    // A taken transfer always passes through execute before the next is taken.
    a_accept_then_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("slave side ready straight after a transfer");

    // A failed operation returns a null handle.
    a_fail_null_handle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_success)
            |-> (r_out_data.out_slot == '0 && r_out_data.out_generation == '0))
        else $error("failed result carries a handle");

    // A pool's live count stays below its high-water mark.
    a_live_below_hw : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.fire |-> ({1'b0, pool_live} < pool_hw))
        else $error("pool live count reaches the high-water mark");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Stream testbench for generational_slot_pool_unit: a directed plan, a wrap churn,
// then random insert/remove/lookup traffic under several capacities, checked against
// plan rows or an in-bench slot pool predictor. Depends on gsp_pkg and the block's RTL.
module testbench;

    import gsp_pkg::*;

    // Codes not named by the package
    localparam logic [KIND_W-1:0]  KIND_NONE   = 2'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_BOX   = 3'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_HULL  = 3'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_PLANE = 3'd4;
    localparam logic [SHAPE_W-1:0] SHAPE_MESH  = 3'd5;
    localparam logic [SHAPE_W-1:0] SHAPE_FIELD = 3'd6;
    localparam logic [SHAPE_W-1:0] SHAPE_SDF   = 3'd7;
    localparam int POOLS       = 3;
    localparam int PLAN_ROWS   = 26;
    localparam int WRAP_ROUNDS = 256;
    localparam int N_PHASES    = 7;
    localparam logic [WORD_W-1:0] ONES = '1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SHAPE_W-1:0] shape;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
        logic [OWNER_W-1:0] owner;
        t_payload           words;   // index 0 is payload_a
    } pool_op_t;

    typedef struct packed {
        logic               success;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
        logic [OWNER_W-1:0] owner;
        t_payload           words;
        logic [CNT_W-1:0]   count;
    } pool_result_t;

    typedef struct {
        pool_op_t     op;
        bit           typed;    // expectation written out in the plan row
        pool_result_t res;
    } plan_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [IN_USER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CAP_W-1:0]      i_cfg_data;

    generational_slot_pool_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the three shape pools and the capacity
    // ------------------------------------------------------------------
    logic [CAP_W-1:0]   cap_reg;
    logic [SLOT_W-1:0]  link_mem  [POOLS][MAX_SLOTS];
    logic [SLOT_W-1:0]  head      [POOLS];
    logic [CAP_W-1:0]   hwm       [POOLS];
    logic [CNT_W-1:0]   live_cnt  [POOLS];
    logic [GEN_W-1:0]   gen_mem   [POOLS][MAX_SLOTS];
    logic               live_mem  [POOLS][MAX_SLOTS];
    logic [OWNER_W-1:0] owner_mem [POOLS][MAX_SLOTS];
    t_payload           word_mem  [POOLS][MAX_SLOTS];

    pool_result_t pending_results[$];
    plan_row_t    plan[PLAN_ROWS];
    int unsigned  mismatches;
    int unsigned  results_seen;
    int unsigned  burst_left;

    // Capacity as the block sees it: anything above MAX_SLOTS saturates
    function automatic int unsigned usable_cap();
        return (cap_reg > CAP_LIMIT) ? MAX_SLOTS : int'(cap_reg);
    endfunction

    function automatic bit handle_valid(int p, int unsigned s, logic [GEN_W-1:0] g);
        if (s == 0 || s > usable_cap() || s >= hwm[p]) return 1'b0;
        return live_mem[p][s] && (gen_mem[p][s] == g);
    endfunction

    // Advance the pool mirror by one operation and return the result it gives
    function automatic pool_result_t pool_apply(pool_op_t op);
        pool_result_t r;
        int           p;
        int unsigned  s;
        logic [GEN_W-1:0] g;
        bit           known;
        r = '0;
        p = int'(op.shape);
        known = (p < POOLS);
        case (op.kind)
            KIND_INSERT: begin
                if (op.owner != '0 && known) begin
                    // free-list head first, else the high-water mark
                    s = 0;
                    if (head[p] != '0) begin
                        s = head[p];
                        head[p] = link_mem[p][s];
                    end else if (hwm[p] < usable_cap()) begin
                        s = hwm[p];
                        hwm[p] = hwm[p] + 1'b1;
                    end
                    if (s != 0) begin
                        g = (gen_mem[p][s] == GEN_MAX) ? GEN_FIRST : gen_mem[p][s] + 1'b1;
                        gen_mem[p][s]   = g;
                        live_mem[p][s]  = 1'b1;
                        owner_mem[p][s] = op.owner;
                        word_mem[p][s]  = op.words;
                        live_cnt[p]     = live_cnt[p] + 1'b1;
                        r.success = 1'b1;
                        r.slot    = s;
                        r.gen     = g;
                    end
                end
            end
            KIND_REMOVE: begin
                if (known && handle_valid(p, op.slot, op.gen)) begin
                    live_mem[p][op.slot] = 1'b0;
                    link_mem[p][op.slot] = head[p];
                    head[p]     = op.slot;
                    live_cnt[p] = live_cnt[p] - 1'b1;
                    r.success = 1'b1;
                    r.slot    = op.slot;
                    r.gen     = op.gen;
                end
            end
            KIND_LOOKUP: begin
                if (known && handle_valid(p, op.slot, op.gen)) begin
                    r.success = 1'b1;
                    r.slot    = op.slot;
                    r.gen     = op.gen;
                    r.owner   = owner_mem[p][op.slot];
                    r.words   = word_mem[p][op.slot];
                    // spheres have no extent word, capsules no half z
                    if (op.shape == SHAPE_SPHERE) begin
                        r.words[4] = '0;
                    end else if (op.shape == SHAPE_CAPSULE) begin
                        r.words[4][63:32] = '0;
                    end
                end
            end
            default: ;
        endcase
        r.count = known ? live_cnt[p] : '0;
        return r;
    endfunction

    function automatic pool_op_t mk_op(logic [KIND_W-1:0] kind, logic [SHAPE_W-1:0] shape,
                                       int unsigned slot, int unsigned gen,
                                       logic [OWNER_W-1:0] owner, logic [WORD_W-1:0] fill);
        pool_op_t op;
        op.kind  = kind;
        op.shape = shape;
        op.slot  = slot;
        op.gen   = gen;
        op.owner = owner;
        op.words = {N_WORDS{fill}};
        return op;
    endfunction

    function automatic pool_result_t mk_res(bit ok, int unsigned slot, int unsigned gen,
                                            logic [OWNER_W-1:0] owner,
                                            logic [WORD_W-1:0] fill, logic [WORD_W-1:0] word_e,
                                            int unsigned count);
        pool_result_t r;
        r.success  = ok;
        r.slot     = slot;
        r.gen      = gen;
        r.owner    = owner;
        r.words    = {N_WORDS{fill}};
        r.words[4] = word_e;
        r.count    = count;
        return r;
    endfunction

    function automatic pool_op_t random_words(pool_op_t op);
        for (int w = 0; w < N_WORDS; w++) op.words[w] = {$urandom, $urandom};
        return op;
    endfunction

    // Random operation: mostly handles that point at live slots, with some
    // stale generations, wild slots, null owners and unsupported shapes mixed in
    function automatic pool_op_t random_op();
        pool_op_t    op;
        int unsigned pick;
        int unsigned p;
        int unsigned s;
        pick = $urandom_range(99);
        p    = $urandom_range(POOLS - 1);
        op   = random_words('0);
        op.shape = ($urandom_range(9) == 0) ? SHAPE_W'($urandom_range(3, 7)) : SHAPE_W'(p);
        op.owner = ($urandom_range(19) == 0) ? '0 : $urandom;
        op.slot  = $urandom_range(MAX_SLOTS - 1);
        op.gen   = $urandom_range(255);
        if (pick < 40)      op.kind = KIND_INSERT;
        else if (pick < 65) op.kind = KIND_REMOVE;
        else if (pick < 95) op.kind = KIND_LOOKUP;
        else                op.kind = KIND_NONE;
        if (op.kind != KIND_INSERT && hwm[p] > 1 && $urandom_range(3) != 0) begin
            s = $urandom_range(1, hwm[p] - 1);
            for (int t = 0; t < 6 && !live_mem[p][s]; t++) s = $urandom_range(1, hwm[p] - 1);
            op.slot = s;
            op.gen  = gen_mem[p][s];
            if ($urandom_range(6) == 0) op.gen = op.gen ^ GEN_W'($urandom_range(1, 255));
        end
        return op;
    endfunction

    // Queue the expectation, then offer the transfer. The sender works in
    // bursts; between bursts it may drop tvalid for a random gap.
    task automatic stream_op(input pool_op_t op, input pool_result_t res);
        t_in_data    din;
        int unsigned gap;
        pending_results.push_back(res);
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        end
        burst_left--;
        din            = '0;
        din.slot       = op.slot;
        din.generation = op.gen;
        din.owner_id   = op.owner;
        din.payload_a  = op.words[0];
        din.payload_b  = op.words[1];
        din.payload_c  = op.words[2];
        din.payload_d  = op.words[3];
        din.payload_e  = op.words[4];
        @(negedge i_clk);
        i_s_axis_tdata  = din;
        i_s_axis_tuser  = {op.shape, op.kind};
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Drop tvalid and hold until every expected result has drained
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the capacity register while the block is idle
    task automatic cfg_write(input int unsigned value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cap_reg = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %h got %h", results_seen, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Receiver: stall in spans of always-ready, coin-flip and a rotating mask
    // ------------------------------------------------------------------
    initial begin
        int unsigned      mode;
        int unsigned      span;
        logic [7:0]       mask;
        i_m_axis_tready = 1'b0;
        forever begin
            mode = $urandom_range(2);
            span = $urandom_range(20, 80);
            mask = 8'($urandom_range(255)) | 8'h01;
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_m_axis_tready = 1'b1;
                    1:       i_m_axis_tready = $urandom_range(1);
                    default: i_m_axis_tready = mask[k % 8];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted transfer with the oldest
    // expectation, field by field
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_data    dout;
        pool_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            dout = o_m_axis_tdata;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: arrived with nothing expected", results_seen);
            end else begin
                want = pending_results.pop_front();
                check_field("success", want.success, o_m_axis_tuser[0]);
                check_field("out_slot", want.slot, dout.out_slot);
                check_field("out_generation", want.gen, dout.out_generation);
                check_field("out_owner", want.owner, dout.out_owner);
                check_field("out_payload_a", want.words[0], dout.out_payload_a);
                check_field("out_payload_b", want.words[1], dout.out_payload_b);
                check_field("out_payload_c", want.words[2], dout.out_payload_c);
                check_field("out_payload_d", want.words[3], dout.out_payload_d);
                check_field("out_payload_e", want.words[4], dout.out_payload_e);
                check_field("pool_live_count", want.count, dout.pool_live_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        pool_op_t     op;
        pool_result_t r;
        int unsigned  cap_plan [N_PHASES];
        int unsigned  len_plan [N_PHASES];

        // Drive every input to a known value and hold reset
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        mismatches      = 0;
        results_seen    = 0;
        burst_left      = 0;

        // Mirror the reset state: empty lists, high-water mark at one
        cap_reg = CAP_RESET;
        for (int p = 0; p < POOLS; p++) begin
            head[p]     = '0;
            hwm[p]      = HW_RESET;
            live_cnt[p] = '0;
            for (int s = 0; s < MAX_SLOTS; s++) begin
                link_mem[p][s]  = '0;
                gen_mem[p][s]   = '0;
                live_mem[p][s]  = 1'b0;
                owner_mem[p][s] = '0;
                word_mem[p][s]  = '0;
            end
        end

        // Directed plan at the reset capacity. Rows whose outcome is plain
        // carry it; the rest fall back on the predictor.
        plan[0]  = '{mk_op(KIND_LOOKUP, SHAPE_SPHERE, 1, 1, 1, 0), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 0)};                     // nothing allocated yet
        plan[1]  = '{mk_op(KIND_INSERT, SHAPE_SPHERE, 0, 0, 0, ONES), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 0)};                     // null owner
        plan[2]  = '{mk_op(KIND_INSERT, SHAPE_HULL, 0, 0, 1, ONES), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 0)};                     // unsupported shape
        plan[3]  = '{mk_op(KIND_INSERT, SHAPE_SDF, 1023, 255, '1, ONES), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 0)};
        plan[4]  = '{mk_op(KIND_INSERT, SHAPE_SPHERE, 0, 0, '1, ONES), 1,
                     mk_res(1, 1, 1, 0, 0, 0, 1)};
        plan[5]  = '{mk_op(KIND_INSERT, SHAPE_BOX, 0, 0, 1, ONES), 1,
                     mk_res(1, 1, 1, 0, 0, 0, 1)};
        plan[6]  = '{mk_op(KIND_INSERT, SHAPE_CAPSULE, 0, 0, 32'h8000_0000, ONES), 1,
                     mk_res(1, 1, 1, 0, 0, 0, 1)};
        plan[7]  = '{mk_op(KIND_LOOKUP, SHAPE_SPHERE, 1, 1, 0, 0), 1,
                     mk_res(1, 1, 1, '1, ONES, 0, 1)};                 // sphere drops word e
        plan[8]  = '{mk_op(KIND_LOOKUP, SHAPE_BOX, 1, 1, 0, 0), 1,
                     mk_res(1, 1, 1, 1, ONES, ONES, 1)};
        plan[9]  = '{mk_op(KIND_LOOKUP, SHAPE_CAPSULE, 1, 1, 0, 0), 1,
                     mk_res(1, 1, 1, 32'h8000_0000, ONES, 64'h0000_0000_FFFF_FFFF, 1)};
        plan[10] = '{mk_op(KIND_LOOKUP, SHAPE_SPHERE, 1, 2, 0, 0), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 1)};                     // stale generation
        plan[11] = '{mk_op(KIND_LOOKUP, SHAPE_BOX, 2, 0, 0, 0), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 1)};                     // at the high-water mark
        plan[12] = '{mk_op(KIND_LOOKUP, SHAPE_SPHERE, 1023, 255, '1, ONES), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 1)};
        plan[13] = '{mk_op(KIND_NONE, SHAPE_SPHERE, 1, 1, 1, ONES), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 1)};                     // unused kind
        plan[14] = '{mk_op(KIND_NONE, SHAPE_MESH, 1, 1, 1, 0), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 0)};
        plan[15] = '{mk_op(KIND_REMOVE, SHAPE_SPHERE, 1, 1, 0, 0), 1,
                     mk_res(1, 1, 1, 0, 0, 0, 0)};
        plan[16] = '{mk_op(KIND_REMOVE, SHAPE_SPHERE, 1, 1, 0, 0), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 0)};                     // already freed
        plan[17] = '{mk_op(KIND_LOOKUP, SHAPE_SPHERE, 1, 1, 0, 0), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 0)};
        plan[18] = '{mk_op(KIND_INSERT, SHAPE_SPHERE, 0, 0, 32'h1234_5678, 0), 1,
                     mk_res(1, 1, 2, 0, 0, 0, 1)};                     // reuse from free list
        plan[19] = '{mk_op(KIND_REMOVE, SHAPE_BOX, 0, 0, 0, 0), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 1)};                     // null handle
        plan[20] = '{mk_op(KIND_LOOKUP, SHAPE_PLANE, 1, 1, 0, 0), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 0)};
        plan[21] = '{mk_op(KIND_REMOVE, SHAPE_FIELD, 1, 1, 0, 0), 1,
                     mk_res(0, 0, 0, 0, 0, 0, 0)};
        plan[22] = '{mk_op(KIND_INSERT, SHAPE_BOX, 0, 0, 32'hA5A5_5A5A,
                           64'h5555_5555_5555_5555), 0, '0};
        plan[23] = '{mk_op(KIND_LOOKUP, SHAPE_BOX, 2, 1, 0, 0), 0, '0};
        plan[24] = '{mk_op(KIND_INSERT, SHAPE_CAPSULE, 0, 0, '1,
                           64'hAAAA_AAAA_AAAA_AAAA), 0, '0};
        plan[25] = '{mk_op(KIND_LOOKUP, SHAPE_CAPSULE, 2, 1, 0, 0), 0, '0};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            r = pool_apply(plan[i].op);
            stream_op(plan[i].op, plan[i].typed ? plan[i].res : r);
        end

        // Churn sphere slot 1 for WRAP_ROUNDS rounds so its generation wraps past 255 back to 1;
        // the free list is LIFO, so each insert hands the same slot back
        for (int i = 0; i < WRAP_ROUNDS; i++) begin
            op = mk_op(KIND_REMOVE, SHAPE_SPHERE, 1, gen_mem[0][1], 0, 0);
            stream_op(op, pool_apply(op));
            op = random_words(mk_op(KIND_INSERT, SHAPE_SPHERE, 0, 0, $urandom | 32'h1, 0));
            stream_op(op, pool_apply(op));
            if (i % 16 == 15 || gen_mem[0][1] <= GEN_FIRST) begin
                op = mk_op(KIND_LOOKUP, SHAPE_SPHERE, 1, gen_mem[0][1], 0, 0);
                stream_op(op, pool_apply(op));
            end
        end

        // Random phases across capacities: tiny pools to hit the full case,
        // zero and the maximum, then a lowered capacity with a high
        // high-water mark so the free list hands out slots above the limit
        cap_plan = '{4, 0, 1, 2, 1024, 3, 1024};
        len_plan = '{70, 30, 25, 35, 120, 50, 30};
        for (int ph = 0; ph < N_PHASES; ph++) begin
            cfg_write(cap_plan[ph]);
            for (int i = 0; i < len_plan[ph]; i++) begin
                op = random_op();
                stream_op(op, pool_apply(op));
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: generational_slot_pool_unit.f
rtl/core/gsp_pkg.sv
rtl/core/gsp_ram.sv
rtl/core/gsp_seq.sv
rtl/core/gsp_pool.sv
rtl/core/gsp_exec.sv
rtl/core/generational_slot_pool_unit.sv
tb/sv/testbench.sv
